### rtl/assert_macros.svh
// assertion helpers, clocked on clock and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/crcsalt_pkg.sv
package crcsalt_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
   localparam logic [5:0] SALTED_MAX_BYTES = 6'd60;
   localparam logic [5:0] COUNT_MAX = 6'd63;
   localparam logic [8:0] MOD_BASE = 9'd255;

   typedef struct packed {
      logic [31:0] crc;
      logic [31:0] seq_num;
      logic        salted;
      logic        dropped;
   } crcsalt_token_type;

   // one entry of the reflected crc table
   function automatic logic [31:0] crc_table_word(logic [7:0] idx);
      logic [31:0] v;
      v = {24'h000000, idx};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

   function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
      logic [31:0] x;
      x = crc ^ {24'h000000, b};
      return crc_table_word(x[7:0]) ^ {8'h00, x[31:8]};
   endfunction

   // byte of the little-endian table image
   function automatic logic [7:0] salt_byte(logic [9:0] off);
      logic [31:0] w;
      w = crc_table_word(off[9:2]);
      return w[{off[1:0], 3'b000} +: 8];
   endfunction

   // mag mod 1020 as 4 * ((mag >> 2) mod 255) + low bits, with 256 == 1 mod 255
   function automatic logic [9:0] salt_offset(logic [31:0] mag);
      logic [29:0] q;
      logic [9:0]  s1;
      logic [8:0]  s2;
      logic [7:0]  r;
      q  = mag[31:2];
      s1 = 10'(q[7:0]) + 10'(q[15:8]) + 10'(q[23:16]) + 10'(q[29:24]);
      s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
      r  = (s2 >= MOD_BASE) ? 8'(s2 - MOD_BASE) : s2[7:0];
      return {r, mag[1:0]};
   endfunction

endpackage

### rtl/crcsalt_tail.sv
module crcsalt_tail (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tok_valid,
   output logic                           tok_ready,
   input  crcsalt_pkg::crcsalt_token_type tok,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_crc_value,
   output logic [7:0]                     rsp_check_byte,
   output logic                           rsp_truncated
);

   logic                           s1_v_ff, s1_v_in;
   crcsalt_pkg::crcsalt_token_type s1_tok_ff, s1_tok_in;

   logic        s2_v_ff, s2_v_in;
   logic [31:0] s2_crc_ff, s2_crc_in;
   logic [9:0]  s2_off_ff, s2_off_in;
   logic        s2_salted_ff, s2_salted_in;
   logic        s2_dropped_ff, s2_dropped_in;

   logic        s3_v_ff, s3_v_in;
   logic [31:0] s3_crc_ff, s3_crc_in;
   logic [7:0]  s3_b0_ff, s3_b0_in;
   logic [7:0]  s3_b1_ff, s3_b1_in;
   logic [7:0]  s3_b2_ff, s3_b2_in;
   logic [7:0]  s3_b3_ff, s3_b3_in;
   logic        s3_salted_ff, s3_salted_in;
   logic        s3_dropped_ff, s3_dropped_in;

   logic        s4_v_ff, s4_v_in;
   logic [31:0] s4_crc_ff, s4_crc_in;
   logic [7:0]  s4_b2_ff, s4_b2_in;
   logic [7:0]  s4_b3_ff, s4_b3_in;
   logic        s4_salted_ff, s4_salted_in;
   logic        s4_dropped_ff, s4_dropped_in;

   logic        out_v_ff, out_v_in;
   logic [31:0] out_crc_ff, out_crc_in;
   logic        out_trunc_ff, out_trunc_in;

   logic        s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
   logic [31:0] mag;

   assign out_ready = !out_v_ff || rsp_ready;
   assign s4_ready  = !s4_v_ff || out_ready;
   assign s3_ready  = !s3_v_ff || s4_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign tok_ready = s1_ready;

   assign mag = s1_tok_ff.seq_num[31] ? (~s1_tok_ff.seq_num + 32'd1) : s1_tok_ff.seq_num;

   always_comb begin
      s1_v_in   = s1_ready ? tok_valid : s1_v_ff;
      s1_tok_in = (s1_ready && tok_valid) ? tok : s1_tok_ff;

      s2_v_in       = s2_ready ? s1_v_ff : s2_v_ff;
      s2_crc_in     = s2_crc_ff;
      s2_off_in     = s2_off_ff;
      s2_salted_in  = s2_salted_ff;
      s2_dropped_in = s2_dropped_ff;
      if (s2_ready && s1_v_ff) begin
         s2_crc_in     = s1_tok_ff.crc;
         s2_off_in     = crcsalt_pkg::salt_offset(mag);
         s2_salted_in  = s1_tok_ff.salted;
         s2_dropped_in = s1_tok_ff.dropped;
      end

      s3_v_in       = s3_ready ? s2_v_ff : s3_v_ff;
      s3_crc_in     = s3_crc_ff;
      s3_b0_in      = s3_b0_ff;
      s3_b1_in      = s3_b1_ff;
      s3_b2_in      = s3_b2_ff;
      s3_b3_in      = s3_b3_ff;
      s3_salted_in  = s3_salted_ff;
      s3_dropped_in = s3_dropped_ff;
      if (s3_ready && s2_v_ff) begin
         s3_crc_in     = s2_crc_ff;
         s3_b0_in      = crcsalt_pkg::salt_byte(s2_off_ff);
         s3_b1_in      = crcsalt_pkg::salt_byte(s2_off_ff + 10'd1);
         s3_b2_in      = crcsalt_pkg::salt_byte(s2_off_ff + 10'd2);
         s3_b3_in      = crcsalt_pkg::salt_byte(s2_off_ff + 10'd3);
         s3_salted_in  = s2_salted_ff;
         s3_dropped_in = s2_dropped_ff;
      end

      s4_v_in       = s4_ready ? s3_v_ff : s4_v_ff;
      s4_crc_in     = s4_crc_ff;
      s4_b2_in      = s4_b2_ff;
      s4_b3_in      = s4_b3_ff;
      s4_salted_in  = s4_salted_ff;
      s4_dropped_in = s4_dropped_ff;
      if (s4_ready && s3_v_ff) begin
         s4_crc_in     = s3_salted_ff
            ? crcsalt_pkg::crc_fold(crcsalt_pkg::crc_fold(s3_crc_ff, s3_b0_ff), s3_b1_ff)
            : s3_crc_ff;
         s4_b2_in      = s3_b2_ff;
         s4_b3_in      = s3_b3_ff;
         s4_salted_in  = s3_salted_ff;
         s4_dropped_in = s3_dropped_ff;
      end

      out_v_in     = out_ready ? s4_v_ff : out_v_ff;
      out_crc_in   = out_crc_ff;
      out_trunc_in = out_trunc_ff;
      if (out_ready && s4_v_ff) begin
         out_crc_in   = crcsalt_pkg::CRC_ONES ^ (s4_salted_ff
            ? crcsalt_pkg::crc_fold(crcsalt_pkg::crc_fold(s4_crc_ff, s4_b2_ff), s4_b3_ff)
            : s4_crc_ff);
         out_trunc_in = s4_salted_ff && s4_dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         s4_v_ff  <= s4_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tok_ff     <= s1_tok_in;
      s2_crc_ff     <= s2_crc_in;
      s2_off_ff     <= s2_off_in;
      s2_salted_ff  <= s2_salted_in;
      s2_dropped_ff <= s2_dropped_in;
      s3_crc_ff     <= s3_crc_in;
      s3_b0_ff      <= s3_b0_in;
      s3_b1_ff      <= s3_b1_in;
      s3_b2_ff      <= s3_b2_in;
      s3_b3_ff      <= s3_b3_in;
      s3_salted_ff  <= s3_salted_in;
      s3_dropped_ff <= s3_dropped_in;
      s4_crc_ff     <= s4_crc_in;
      s4_b2_ff      <= s4_b2_in;
      s4_b3_ff      <= s4_b3_in;
      s4_salted_ff  <= s4_salted_in;
      s4_dropped_ff <= s4_dropped_in;
      out_crc_ff    <= out_crc_in;
      out_trunc_ff  <= out_trunc_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_crc_value  = out_crc_ff;
   assign rsp_check_byte = out_crc_ff[7:0];
   assign rsp_truncated  = out_trunc_ff;

endmodule

### rtl/crc32_stream_with_sequence_salt.sv
// Streaming reflected CRC-32 with an optional sequence salt.
// Request channel (req_valid/req_ready): one byte per request with data_present,
// first and last flags and a signed sequence number. Only a request with last
// set produces a response on the rsp_valid/rsp_ready channel: the inverted CRC,
// its low byte as check byte, and the truncated flag.
// csr_valid/csr_ready writes salted_mode; csr_ready is always high. Write it only
// while no message is in flight. In salted mode bytes beyond 60 per message are
// dropped and flagged, and four salt bytes picked by |sequence| mod 1020 from the
// CRC table are folded in before the inversion.
// Throughput: one request per cycle; the running CRC takes one table step per
// byte in the input stage.
// Path: a last request passes from the input stage through the token register,
// offset stage, salt lookup, first fold stage, and the second fold into the
// output register, where its response is valid.
// Reset: synchronous; clears the pipeline, running CRC to all ones, byte count
// and drop flag to zero, salted_mode to 0.
// Stall: while rsp_ready is low the response holds; requests without last keep
// flowing, a last request waits in the input stage once the five tail stages
// are full and req_ready stays low until it moves on.
`include "assert_macros.svh"

module crc32_stream_with_sequence_salt #(
   parameter logic [5:0] SALTED_MAX_BYTES = crcsalt_pkg::SALTED_MAX_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_data_present,
   input  logic        req_first,
   input  logic        req_last,
   input  logic signed [31:0] req_sequence_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_crc_value,
   output logic [7:0]  rsp_check_byte,
   output logic        rsp_truncated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_salted_mode
);

   logic        in_v_ff, in_v_in;
   logic [7:0]  in_data_ff, in_data_in;
   logic        in_present_ff, in_present_in;
   logic        in_first_ff, in_first_in;
   logic        in_last_ff, in_last_in;
   logic [31:0] in_seq_ff, in_seq_in;

   logic [31:0] crc_ff, crc_in;
   logic [5:0]  count_ff, count_in;
   logic        dropped_ff, dropped_in;
   logic        mode_ff, mode_in;

   logic        in_go;
   logic        tok_valid, tok_ready;
   logic [31:0] crc_base, crc_next;
   logic [5:0]  count_base, count_next;
   logic        dropped_base, dropped_next;
   crcsalt_pkg::crcsalt_token_type tok;

   assign csr_ready = 1'b1;
   assign in_go     = in_v_ff && (!in_last_ff || tok_ready);
   assign req_ready = !in_v_ff || in_go;
   assign tok_valid = in_v_ff && in_last_ff;

   always_comb begin
      in_v_in       = req_ready ? req_valid : in_v_ff;
      in_data_in    = in_data_ff;
      in_present_in = in_present_ff;
      in_first_in   = in_first_ff;
      in_last_in    = in_last_ff;
      in_seq_in     = in_seq_ff;
      if (req_valid && req_ready) begin
         in_data_in    = req_data_byte;
         in_present_in = req_data_present;
         in_first_in   = req_first;
         in_last_in    = req_last;
         in_seq_in     = req_sequence_req;
      end
      mode_in = (csr_valid && csr_ready) ? csr_salted_mode : mode_ff;
   end

   // running crc update for the request in the input stage
   always_comb begin
      crc_base     = in_first_ff ? crcsalt_pkg::CRC_ONES : crc_ff;
      count_base   = in_first_ff ? 6'd0 : count_ff;
      dropped_base = in_first_ff ? 1'b0 : dropped_ff;
      crc_next     = crc_base;
      count_next   = count_base;
      dropped_next = dropped_base;
      if (in_present_ff) begin
         if (mode_ff && (count_base >= SALTED_MAX_BYTES)) begin
            dropped_next = 1'b1;
         end else begin
            crc_next = crcsalt_pkg::crc_fold(crc_base, in_data_ff);
            if (count_base != crcsalt_pkg::COUNT_MAX) begin
               count_next = count_base + 6'd1;
            end
         end
      end

      tok.crc     = crc_next;
      tok.seq_num = in_seq_ff;
      tok.salted  = mode_ff;
      tok.dropped = dropped_next;

      crc_in     = crc_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (in_go) begin
         if (in_last_ff) begin
            crc_in     = crcsalt_pkg::CRC_ONES;
            count_in   = 6'd0;
            dropped_in = 1'b0;
         end else begin
            crc_in     = crc_next;
            count_in   = count_next;
            dropped_in = dropped_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff    <= 1'b0;
         crc_ff     <= crcsalt_pkg::CRC_ONES;
         count_ff   <= 6'd0;
         dropped_ff <= 1'b0;
         mode_ff    <= 1'b0;
      end else begin
         in_v_ff    <= in_v_in;
         crc_ff     <= crc_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         mode_ff    <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff    <= in_data_in;
      in_present_ff <= in_present_in;
      in_first_ff   <= in_first_in;
      in_last_ff    <= in_last_in;
      in_seq_ff     <= in_seq_in;
   end

   crcsalt_tail u_tail (
      .clock          (clock),
      .reset          (reset),
      .tok_valid      (tok_valid),
      .tok_ready      (tok_ready),
      .tok            (tok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_value  (rsp_crc_value),
      .rsp_check_byte (rsp_check_byte),
      .rsp_truncated  (rsp_truncated)
   );

   `ASSERT_HOLDS(a_stall_needs_request, !req_ready, in_v_ff)
   `ASSERT_NEXT(a_clean_after_last, in_go && in_last_ff,
      (crc_ff == crcsalt_pkg::CRC_ONES) && (count_ff == 6'd0) && !dropped_ff)
   `ASSERT_HOLDS(a_unsalted_not_truncated, rsp_valid && !mode_ff, !rsp_truncated)

endmodule

### sim/crc32_stream_with_sequence_salt_tb.sv
`timescale 1ns / 1ps

module crc32_stream_with_sequence_salt_tb;

   localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam int unsigned SALT_SPAN = 1020;
   localparam int MAX_FOLDED = 60;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [31:0] crc;
      logic [7:0]  chk;
      logic        trunc;
   } crc_result_type;

   class crc_salt_model;
      crc_result_type expected_crcs[$];
      logic [31:0] running_crc;
      logic [5:0]  folded_count;
      logic        dropped;
      logic        salted;
      int          errors;

      function new();
         clear_message();
         salted = 1'b0;
         errors = 0;
      endfunction

      function void clear_message();
         running_crc = ALL_ONES;
         folded_count = '0;
         dropped = 1'b0;
      endfunction

      function void set_mode(logic m);
         salted = m;
      endfunction

      function int pending();
         return expected_crcs.size();
      endfunction

      // one byte through the reflected polynomial, bit by bit
      function logic [31:0] fold_byte(logic [31:0] crc, logic [7:0] b);
         logic [31:0] v;
         v = crc ^ {24'h0, b};
         for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ POLY_REFLECTED) : (v >> 1);
         end
         return v;
      endfunction

      function logic [7:0] salt_table_byte(int unsigned offset);
         logic [31:0] w;
         w = fold_byte(32'h0, 8'(offset >> 2));
         return 8'(w >> (8 * (offset % 4)));
      endfunction

      function void note_request(logic [7:0] data, logic present, logic first_f,
                                 logic last_f, logic signed [31:0] seq);
         logic [31:0] crc;
         logic [31:0] mag;
         int unsigned off;
         crc_result_type r;
         if (first_f) clear_message();
         if (present) begin
            if (salted && folded_count >= MAX_FOLDED) begin
               dropped = 1'b1;
            end else begin
               running_crc = fold_byte(running_crc, data);
               if (folded_count != 6'd63) folded_count++;
            end
         end
         if (!last_f) return;
         crc = running_crc;
         r.trunc = 1'b0;
         if (salted) begin
            mag = seq[31] ? (~seq + 32'd1) : seq;
            off = mag % SALT_SPAN;
            for (int k = 0; k < 4; k++) begin
               crc = fold_byte(crc, salt_table_byte(off + k));
            end
            r.trunc = dropped;
         end
         r.crc = crc ^ ALL_ONES;
         r.chk = r.crc[7:0];
         expected_crcs.push_back(r);
         clear_message();
      endfunction

      function void check_response(logic [31:0] crc, logic [7:0] chk, logic trunc);
         crc_result_type e;
         if (expected_crcs.size() == 0) begin
            $error("unexpected response crc_value %h", crc);
            errors++;
            return;
         end
         e = expected_crcs.pop_front();
         if (crc !== e.crc) begin
            $error("crc_value: expected %h, got %h", e.crc, crc);
            errors++;
         end
         if (chk !== e.chk) begin
            $error("check_byte: expected %h, got %h", e.chk, chk);
            errors++;
         end
         if (trunc !== e.trunc) begin
            $error("truncated: expected %b, got %b", e.trunc, trunc);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = '0;
   logic req_data_present = 1'b0;
   logic req_first = 1'b0;
   logic req_last = 1'b0;
   logic signed [31:0] req_sequence_req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_crc_value;
   logic [7:0] rsp_check_byte;
   logic rsp_truncated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_salted_mode = 1'b0;

   int idle_pct = 21;
   int stall_pct = 21;
   int cycle_count = 0;

   crc_salt_model model = new();

   crc32_stream_with_sequence_salt uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_data_present(req_data_present),
      .req_first(req_first),
      .req_last(req_last),
      .req_sequence_req(req_sequence_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_crc_value(rsp_crc_value),
      .rsp_check_byte(rsp_check_byte),
      .rsp_truncated(rsp_truncated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_salted_mode(csr_salted_mode)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         model.check_response(rsp_crc_value, rsp_check_byte, rsp_truncated);
      end
   end

   task automatic send_request(logic [7:0] data, logic present, logic first_f,
                               logic last_f, logic signed [31:0] seq);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_data_present <= present;
      req_first <= first_f;
      req_last <= last_f;
      req_sequence_req <= seq;
      do @(posedge clock); while (!req_ready);
      model.note_request(data, present, first_f, last_f, seq);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      csr_valid <= 1'b1;
      csr_salted_mode <= m;
      do @(posedge clock); while (!csr_ready);
      model.set_mode(m);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_sequence();
      int unsigned sel;
      logic [31:0] v;
      sel = $urandom_range(0, 9);
      case (sel)
         0: v = 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         2: v = 32'h0;
         3: v = 32'hFFFF_FFFF;
         4: begin
            v = $urandom_range(0, 2100);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic random_phase(int n_items);
      int sent;
      int len;
      int sel;
      logic use_first;
      logic present;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            sel = $urandom_range(0, 99);
            if (sel < 75) len = $urandom_range(1, 16);
            else if (sel < 95) len = $urandom_range(55, 70);
            else len = $urandom_range(1, 3);
            use_first = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len; i++) begin
               if (i == len - 1) present = ($urandom_range(0, 3) != 0);
               else present = ($urandom_range(0, 19) != 0);
               send_request(8'($urandom_range(0, 255)), present, use_first && i == 0,
                            i == len - 1, random_sequence());
            end
            sent += len;
         end else begin
            // broken framing
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         random_sequence());
            sent++;
         end
      end
      send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b1,
                   random_sequence());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(1'b0);
      send_request(8'h00, 1'b1, 1'b1, 1'b1, 32'sd0);
      send_request(8'hFF, 1'b1, 1'b1, 1'b0, 32'sd7);
      send_request(8'h80, 1'b1, 1'b0, 1'b0, 32'sd0);
      send_request(8'h01, 1'b0, 1'b0, 1'b1, 32'sd12345);
      send_request(8'hAA, 1'b1, 1'b0, 1'b1, -32'sd5);
      drain();

      write_mode(1'b1);
      send_request(8'h5A, 1'b1, 1'b1, 1'b1, 32'h8000_0000);
      send_request(8'h00, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF);
      send_request(8'hFF, 1'b1, 1'b1, 1'b1, -32'sd1);
      send_request(8'hC3, 1'b1, 1'b1, 1'b1, 32'sd1019);
      send_request(8'h3C, 1'b1, 1'b1, 1'b1, 32'sd1020);
      send_request(8'h11, 1'b1, 1'b1, 1'b0, 32'sd3);
      send_request(8'h22, 1'b0, 1'b0, 1'b0, 32'sd3);
      send_request(8'h33, 1'b1, 1'b1, 1'b0, 32'sd3);
      send_request(8'h44, 1'b1, 1'b0, 1'b1, -32'sd1020);
      send_request(8'hFF, 1'b1, 1'b1, 1'b1, 32'sd1021);
      drain();

      random_phase(330);
      drain();
      write_mode(1'b0);
      random_phase(330);
      drain();

      // no idling on either side
      idle_pct = 0;
      stall_pct = 0;
      write_mode(1'b1);
      random_phase(330);
      drain();
      idle_pct = 21;
      stall_pct = 21;

      write_mode(1'b0);
      random_phase(330);
      drain();
      write_mode(1'b1);
      random_phase(300);
      drain();
      repeat (20) @(posedge clock);

      if (model.errors == 0 && model.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### crc32_stream_with_sequence_salt.f
+incdir+rtl
rtl/crcsalt_pkg.sv
rtl/crcsalt_tail.sv
rtl/crc32_stream_with_sequence_salt.sv
sim/crc32_stream_with_sequence_salt_tb.sv
